### src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the drive mixer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property that must hold at every clock edge outside reset.
`define ASSERT_AT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define ASSERT_AT(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, cond, msg)

`endif

`endif

### src/dmix_pkg.sv
// ----------------------------------------------------------------------------
// dmix_pkg
// Types and constants shared by the drive mixer front end, queue and back end.
// ----------------------------------------------------------------------------
package dmix_pkg;

   // Command kinds carried on req_tuser.
   localparam logic TYPE_DIFF   = 1'b0;
   localparam logic TYPE_ARCADE = 1'b1;

   // Field widths.
   localparam int DUTY_W     = 9;
   localparam int MAG_W      = 10;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 24;

   // Duty saturation bounds, as magnitudes.
   localparam int DUTY_POS_MAX = 255;
   localparam int DUTY_NEG_MAX = 256;

   // Queue between front and back end.
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   // One classified command: mixed duties split into sign and magnitude.
   typedef struct packed {
      logic             stop;
      logic             need_scale;
      logic             neg_right;
      logic             neg_left;
      logic [MAG_W-1:0] mag_right;
      logic [MAG_W-1:0] mag_left;
      logic [MAG_W-1:0] maxmag;
   } dmix_item_type;

endpackage

### src/differential_drive_mixer_top.sv
// ----------------------------------------------------------------------------
// differential_drive_mixer_top
// Turns differential or arcade-button drive commands into signed right and
// left PWM duties, scaled down to PWM_LIMIT when the mix exceeds it.
// ----------------------------------------------------------------------------
// Usage:
//   Commands arrive on the req_ stream, one beat per command; req_tuser picks
//   differential (0) or arcade buttons (1). Each command yields exactly one
//   rsp_ beat with the right duty, left duty and stop flag.
//   Q = clog2(PWM_LIMIT + 1) is the number of divider stages that each
//   resolve one quotient bit, for both wheels in parallel. One command is
//   accepted every cycle while rsp_tready stays high.
//   When rsp_tready is low the back end holds; a four-entry queue and a
//   holding register in front keep accepting until they fill, then
//   req_tready drops.
//   Reset clears all valid flags and the queue; no other state is kept.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module differential_drive_mixer_top #(
   parameter int PWM_LIMIT = 255
) (
   input  logic        clock,
   input  logic        reset,
   // req_tdata: velocity[8:0], turn[17:9], speed_magnitude[25:18],
   // turn_magnitude[33:26], button_up[34], button_down[35],
   // button_right[36], button_left[37], zero[39:38]
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,
   // req_tuser: req_type[0]
   input  logic        req_tuser,
   // rsp_tdata: right_duty[8:0], left_duty[17:9], stop_request[18],
   // zero[23:19]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata
);
   import dmix_pkg::*;

   logic          front_push;
   dmix_item_type front_item;
   logic          fifo_full;
   logic          fifo_valid;
   dmix_item_type fifo_item;
   logic          fifo_pop;

   // Front end: decode and mix.
   dmix_front #(
      .PWM_LIMIT (PWM_LIMIT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .fifo_full  (fifo_full),
      .push       (front_push),
      .push_item  (front_item)
   );

   // Decoupling queue.
   dmix_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (front_push),
      .push_item (front_item),
      .full      (fifo_full),
      .pop       (fifo_pop),
      .rd_valid  (fifo_valid),
      .rd_item   (fifo_item)
   );

   // Back end: scale, saturate, output.
   dmix_back #(
      .PWM_LIMIT (PWM_LIMIT)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .fifo_valid (fifo_valid),
      .fifo_item  (fifo_item),
      .fifo_pop   (fifo_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // A stop result always carries zero duties.
   `ASSERT_AT(a_stop_zero, clock, reset, rsp_tvalid && rsp_tdata[18] |-> rsp_tdata[17:0] == '0, "stop beat with nonzero duty")

   // The front end never pushes into a full queue.
   `ASSERT_NEVER(a_no_overflow, clock, reset, front_push && fifo_full, "push into full queue")

   // Back pressure on the input only comes from a full queue.
   `ASSERT_AT(a_ready_cause, clock, reset, !req_tready |-> fifo_full, "input stalled while queue has room")

endmodule

### src/dmix_front.sv
// ----------------------------------------------------------------------------
// dmix_front
// Accepts drive commands, resolves arcade buttons, mixes right and left duties
// and decides whether they must be scaled down to the PWM limit.
// ----------------------------------------------------------------------------
module dmix_front #(
   parameter int PWM_LIMIT = 255
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [dmix_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                           req_tuser,
   input  logic                           fifo_full,
   output logic                           push,
   output dmix_pkg::dmix_item_type         push_item
);
   import dmix_pkg::*;

   localparam int LIMIT_W = $clog2(PWM_LIMIT + 1);
   localparam int CMP_W   = (LIMIT_W > MAG_W) ? LIMIT_W : MAG_W;

   logic signed [DUTY_W-1:0] vel_d, trn_d;
   logic        [7:0]        speed_mag, turn_mag;
   logic                     btn_up, btn_down, btn_right, btn_left;
   logic signed [MAG_W-1:0]  vel, trn, right_s, left_s;
   logic        [MAG_W-1:0]  mag_r, mag_l, maxmag;
   logic                     accept;
   dmix_item_type            item_c;
   dmix_item_type            item_ff;
   logic                     vld_ff, vld_in;

   // Unpack the beat.
   assign vel_d     = $signed(req_tdata[8:0]);
   assign trn_d     = $signed(req_tdata[17:9]);
   assign speed_mag = req_tdata[25:18];
   assign turn_mag  = req_tdata[33:26];
   assign btn_up    = req_tdata[34];
   assign btn_down  = req_tdata[35];
   assign btn_right = req_tdata[36];
   assign btn_left  = req_tdata[37];

   // Effective velocity and turn; opposing buttons cancel.
   always_comb begin
      if (req_tuser == TYPE_ARCADE) begin
         if (btn_up && !btn_down) begin
            vel = $signed({2'b00, speed_mag});
         end else if (btn_down && !btn_up) begin
            vel = -$signed({2'b00, speed_mag});
         end else begin
            vel = '0;
         end
         if (btn_right && !btn_left) begin
            trn = $signed({2'b00, turn_mag});
         end else if (btn_left && !btn_right) begin
            trn = -$signed({2'b00, turn_mag});
         end else begin
            trn = '0;
         end
      end else begin
         vel = MAG_W'(vel_d);
         trn = MAG_W'(trn_d);
      end
   end

   // Mix and take magnitudes; -512 reads as 512 unsigned.
   always_comb begin
      right_s = vel + trn;
      left_s  = vel - trn;
      mag_r   = right_s[MAG_W-1] ? MAG_W'(-right_s) : MAG_W'(right_s);
      mag_l   = left_s[MAG_W-1]  ? MAG_W'(-left_s)  : MAG_W'(left_s);
      maxmag  = (mag_r > mag_l) ? mag_r : mag_l;

      item_c.stop       = (vel == '0) && (trn == '0);
      item_c.need_scale = CMP_W'(maxmag) > CMP_W'(PWM_LIMIT);
      item_c.neg_right  = right_s[MAG_W-1];
      item_c.neg_left   = left_s[MAG_W-1];
      item_c.mag_right  = mag_r;
      item_c.mag_left   = mag_l;
      item_c.maxmag     = maxmag;
   end

   // Holding register: takes a beat when empty or when it drains this cycle.
   assign req_tready = !vld_ff || !fifo_full;
   assign accept     = req_tvalid && req_tready;
   assign push       = vld_ff && !fifo_full;
   assign push_item  = item_ff;

   always_comb begin
      if (accept) begin
         vld_in = 1'b1;
      end else if (push) begin
         vld_in = 1'b0;
      end else begin
         vld_in = vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_c;
      end
   end

endmodule

### src/dmix_fifo.sv
// ----------------------------------------------------------------------------
// dmix_fifo
// Short queue of classified commands between the front and back ends.
// ----------------------------------------------------------------------------
module dmix_fifo (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  dmix_pkg::dmix_item_type push_item,
   output logic                    full,
   input  logic                    pop,
   output logic                    rd_valid,
   output dmix_pkg::dmix_item_type rd_item
);
   import dmix_pkg::*;

   dmix_item_type           mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0]   cnt_ff, cnt_in;
   logic                    do_pop;

   assign full     = (cnt_ff == FIFO_CNT_W'(FIFO_DEPTH));
   assign rd_valid = (cnt_ff != '0);
   assign rd_item  = mem_ff[rd_ptr_ff];
   assign do_pop   = pop && rd_valid;

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = push   ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff + FIFO_CNT_W'(push) - FIFO_CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Storage.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

### src/dmix_back.sv
// ----------------------------------------------------------------------------
// dmix_back
// Scales duty magnitudes by PWM_LIMIT / maxmag with a pipelined restoring
// divider, one quotient bit per stage, then saturates and drives the output.
// ----------------------------------------------------------------------------
module dmix_back #(
   parameter int PWM_LIMIT = 255
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            fifo_valid,
   input  dmix_pkg::dmix_item_type          fifo_item,
   output logic                            fifo_pop,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [dmix_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import dmix_pkg::*;

   localparam int QW = $clog2(PWM_LIMIT + 1);
   localparam int DW = MAG_W + QW;
   localparam int RW = (QW > MAG_W) ? QW : MAG_W;

   logic                 advance;
   logic [QW:0]          vld_ff, vld_in;
   dmix_item_type        item_ff  [QW+1];
   dmix_item_type        item_in  [QW+1];
   logic [DW-1:0]        rem_r_ff [QW+1];
   logic [DW-1:0]        rem_r_in [QW+1];
   logic [DW-1:0]        rem_l_ff [QW+1];
   logic [DW-1:0]        rem_l_in [QW+1];
   logic [QW-1:0]        q_r_ff   [QW+1];
   logic [QW-1:0]        q_r_in   [QW+1];
   logic [QW-1:0]        q_l_ff   [QW+1];
   logic [QW-1:0]        q_l_in   [QW+1];
   logic [RW-1:0]        res_r, res_l;
   logic [DUTY_W-1:0]    duty_r, duty_l;
   logic                 rsp_vld_ff;
   logic [DUTY_W-1:0]    duty_r_ff, duty_l_ff;
   logic                 stop_ff;

   // The whole pipeline moves unless a result sits unread at the output.
   assign advance  = !rsp_vld_ff || rsp_tready;
   assign fifo_pop = advance && fifo_valid;

   // Stage 0 forms magnitude * limit; each later stage decides one quotient bit.
   always_comb begin
      logic [DW-1:0] sh;
      logic          ge_r, ge_l;
      vld_in[0]   = fifo_valid;
      item_in[0]  = fifo_item;
      rem_r_in[0] = DW'(fifo_item.mag_right) * DW'(PWM_LIMIT);
      rem_l_in[0] = DW'(fifo_item.mag_left) * DW'(PWM_LIMIT);
      q_r_in[0]   = '0;
      q_l_in[0]   = '0;
      for (int s = 1; s <= QW; s++) begin
         sh          = DW'(item_ff[s-1].maxmag) << (QW - s);
         ge_r        = rem_r_ff[s-1] >= sh;
         ge_l        = rem_l_ff[s-1] >= sh;
         vld_in[s]   = vld_ff[s-1];
         item_in[s]  = item_ff[s-1];
         rem_r_in[s] = ge_r ? rem_r_ff[s-1] - sh : rem_r_ff[s-1];
         rem_l_in[s] = ge_l ? rem_l_ff[s-1] - sh : rem_l_ff[s-1];
         q_r_in[s]   = q_r_ff[s-1] | (QW'(ge_r) << (QW - s));
         q_l_in[s]   = q_l_ff[s-1] | (QW'(ge_l) << (QW - s));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int s = 0; s <= QW; s++) begin
            item_ff[s]  <= item_in[s];
            rem_r_ff[s] <= rem_r_in[s];
            rem_l_ff[s] <= rem_l_in[s];
            q_r_ff[s]   <= q_r_in[s];
            q_l_ff[s]   <= q_l_in[s];
         end
      end
   end

   // Pick scaled or raw magnitude, restore the sign and saturate to 9 bits.
   always_comb begin
      res_r = item_ff[QW].need_scale ? RW'(q_r_ff[QW]) : RW'(item_ff[QW].mag_right);
      res_l = item_ff[QW].need_scale ? RW'(q_l_ff[QW]) : RW'(item_ff[QW].mag_left);
      if (item_ff[QW].neg_right) begin
         duty_r = (res_r > RW'(DUTY_NEG_MAX)) ? DUTY_W'(-DUTY_NEG_MAX) : DUTY_W'(-res_r);
      end else begin
         duty_r = (res_r > RW'(DUTY_POS_MAX)) ? DUTY_W'(DUTY_POS_MAX) : DUTY_W'(res_r);
      end
      if (item_ff[QW].neg_left) begin
         duty_l = (res_l > RW'(DUTY_NEG_MAX)) ? DUTY_W'(-DUTY_NEG_MAX) : DUTY_W'(-res_l);
      end else begin
         duty_l = (res_l > RW'(DUTY_POS_MAX)) ? DUTY_W'(DUTY_POS_MAX) : DUTY_W'(res_l);
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (advance) begin
         rsp_vld_ff <= vld_ff[QW];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         duty_r_ff <= duty_r;
         duty_l_ff <= duty_l;
         stop_ff   <= item_ff[QW].stop;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {(RSP_DATA_W - 2 * DUTY_W - 1)'(0), stop_ff, duty_l_ff, duty_r_ff};

endmodule
